@@ src/oaht_pkg.sv @@
`default_nettype none
package oaht_pkg;

	localparam int KeyW      = 31;
	localparam int TableSize = 1024;
	localparam int AddrW     = 10;

	// Request codes.
	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_REMOVE = 2'd1;
	localparam logic [1:0] REQ_SEARCH = 2'd2;

	// Probe modes.
	localparam logic [1:0] MODE_LINEAR = 2'd0;
	localparam logic [1:0] MODE_QUAD   = 2'd1;
	localparam logic [1:0] MODE_DOUBLE = 2'd2;

	// Status codes.
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_HOME,
		S_PROBE_ADDR,
		S_PROBE_RD,
		S_PROBE_CHK,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_DIV,
		S_DONE
	} state_t;

	// Memory access request from the sequencer.
	typedef struct packed {
		logic             rd;
		logic             wr;
		logic             wr_empty;
		logic [AddrW-1:0] addr;
		logic [KeyW-1:0]  wkey;
	} mem_req_t;

endpackage
`default_nettype wire

@@ src/oaht_mem.sv @@
`default_nettype none
// Slot memory: one synchronous port. Each word holds an empty flag above the
// key; an empty slot reads as all ones. The clearing pass after reset writes
// one slot per cycle.
module oaht_mem (
	input  wire                            clk,
	input  wire                            clr_en,
	input  wire  [oaht_pkg::AddrW-1:0]     clr_addr,
	input  wire  oaht_pkg::mem_req_t       req,
	output logic                           rd_empty,
	output logic [oaht_pkg::KeyW-1:0]      rd_key
);

	logic [oaht_pkg::KeyW:0] mem_q [oaht_pkg::TableSize];
	logic [oaht_pkg::KeyW:0] rd_q;

	// Slot storage, clearing pass and registered read.
	always_ff @(posedge clk) begin
		if (clr_en) begin
			mem_q[clr_addr] <= '1;
		end else if (req.wr) begin
			mem_q[req.addr] <= req.wr_empty ? '1 : {1'b0, req.wkey};
		end
		if (req.rd) begin
			rd_q <= mem_q[req.addr];
		end
	end

	assign rd_empty = rd_q[oaht_pkg::KeyW];
	assign rd_key   = rd_q[oaht_pkg::KeyW-1:0];

endmodule
`default_nettype wire

@@ src/open_addressing_hash_table.sv @@
// A request is decided at its home slot when that slot settles it; search and remove
// then scan the following slots in turn, insert probes by the current mode, and a
// double-hash probe first runs its serial key mod i step.
// Throughput: one request at a time; the next beat is taken only after the result
// beat has been accepted. Reset: asynchronous; a clearing pass marks every slot
// empty first, and probe_mode is linear.
`default_nettype none
module open_addressing_hash_table (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [1:0]  cfg_data,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [31:0] s_tdata,   // key[30:0], zero fill
	input  wire  [1:0]  s_tuser,   // req_type[1:0]
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [55:0] m_tdata,   // slot_index[9:0], occupancy[20:10], collision_total[52:21]
	output logic [1:0]  m_tuser    // status[1:0]
);

	localparam int TableSize = oaht_pkg::TableSize;
	localparam int AddrW     = oaht_pkg::AddrW;
	localparam int CntW = AddrW + 1;
	localparam int PW   = 2 * AddrW + 1;
	localparam logic [CntW-1:0] TSize = CntW'(TableSize);

	oaht_pkg::state_t st_q, st_d;
	oaht_pkg::mem_req_t mreq;
	logic [1:0]  mode_q;
	logic [1:0]  req_q;
	logic [30:0] key_q;
	logic [CntW-1:0] n_q;
	logic [CntW-1:0] occ_q;
	logic [31:0] coll_q;
	logic [AddrW-1:0] addr_q, home;
	logic [AddrW-1:0] clr_q;
	logic rd_empty;
	logic [30:0] rd_key;
	logic [1:0]  st_out_q;
	logic [AddrW-1:0] slot_out_q;
	// key mod i divider
	logic [30:0] rem_q;
	logic [4:0]  dbit_q;
	logic [CntW:0] di;
	logic [31:0] rtry;
	logic [30:0] rnext;

	assign home = key_q[AddrW-1:0];
	assign cfg_ready = 1'b1;
	assign s_tready = (st_q == oaht_pkg::S_IDLE) && !m_tvalid;
	assign m_tdata = {3'b000, coll_q, occ_q, slot_out_q};
	assign m_tuser = st_out_q;

	// Restoring remainder step, one bit per cycle: rem = key mod (n+1).
	assign di = {1'b0, n_q} + 1'b1;
	assign rtry = {rem_q, key_q[dbit_q]} ;
	assign rnext = (rtry >= 32'(di)) ? 31'(rtry - 32'(di)) : rtry[30:0];

	// Probe address for the current attempt.
	logic [PW-1:0] sq;
	logic [AddrW-1:0] paddr;
	always_comb begin
		sq = PW'(n_q) * PW'(n_q);
		unique case (mode_q)
			oaht_pkg::MODE_QUAD:   paddr = AddrW'(key_q[AddrW-1:0] + sq[AddrW-1:0]);
			oaht_pkg::MODE_DOUBLE: paddr = AddrW'(home + AddrW'(di) - rem_q[AddrW-1:0]);
			default:               paddr = AddrW'(home + n_q[AddrW-1:0]);
		endcase
	end

	oaht_mem u_mem (
		.clk(clk),
		.clr_en(st_q == oaht_pkg::S_CLEAR), .clr_addr(clr_q),
		.req(mreq), .rd_empty(rd_empty), .rd_key(rd_key)
	);

	// Next state and memory requests.
	always_comb begin
		st_d = st_q;
		mreq = '0;
		mreq.wkey = key_q;
		mreq.addr = addr_q;
		unique case (st_q)
			oaht_pkg::S_CLEAR: if (clr_q == AddrW'(TableSize - 1)) st_d = oaht_pkg::S_IDLE;
			oaht_pkg::S_IDLE: begin
				if (s_tvalid && s_tready) begin
					mreq.rd = 1'b1;
					mreq.addr = s_tdata[AddrW-1:0];
					st_d = (s_tuser == oaht_pkg::REQ_INSERT) ? oaht_pkg::S_HOME
						: oaht_pkg::S_SCAN_CHK;
				end
			end
			oaht_pkg::S_HOME: begin
				if (rd_empty) begin
					mreq.wr = 1'b1;
					st_d = oaht_pkg::S_DONE;
				end else if (occ_q >= TSize) begin
					st_d = oaht_pkg::S_DONE;
				end else begin
					st_d = (mode_q == oaht_pkg::MODE_DOUBLE) ? oaht_pkg::S_DIV
						: oaht_pkg::S_PROBE_ADDR;
				end
			end
			oaht_pkg::S_DIV: if (dbit_q == 5'd0) st_d = oaht_pkg::S_PROBE_ADDR;
			oaht_pkg::S_PROBE_ADDR: st_d = oaht_pkg::S_PROBE_RD;
			oaht_pkg::S_PROBE_RD: begin
				mreq.rd = 1'b1;
				st_d = oaht_pkg::S_PROBE_CHK;
			end
			oaht_pkg::S_PROBE_CHK: begin
				if (rd_empty) begin
					mreq.wr = 1'b1;
					st_d = oaht_pkg::S_DONE;
				end else if (n_q == TSize - 1'b1) begin
					st_d = oaht_pkg::S_DONE;
				end else begin
					st_d = (mode_q == oaht_pkg::MODE_DOUBLE) ? oaht_pkg::S_DIV
						: oaht_pkg::S_PROBE_ADDR;
				end
			end
			oaht_pkg::S_SCAN_RD: begin
				mreq.rd = 1'b1;
				st_d = oaht_pkg::S_SCAN_CHK;
			end
			oaht_pkg::S_SCAN_CHK: begin
				if (!rd_empty && rd_key == key_q) begin
					if (req_q == oaht_pkg::REQ_REMOVE) begin
						mreq.wr = 1'b1;
						mreq.wr_empty = 1'b1;
					end
					st_d = oaht_pkg::S_DONE;
				end else if (n_q == TSize - 1'b1) begin
					st_d = oaht_pkg::S_DONE;
				end else begin
					st_d = oaht_pkg::S_SCAN_RD;
				end
			end
			oaht_pkg::S_DONE: st_d = oaht_pkg::S_IDLE;
			default: st_d = oaht_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= oaht_pkg::S_CLEAR;
		end else begin
			st_q <= st_d;
		end
	end

	// Datapath and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0; mode_q <= oaht_pkg::MODE_LINEAR; occ_q <= '0; coll_q <= '0;
			m_tvalid <= 1'b0; n_q <= '0; req_q <= '0; key_q <= '0; addr_q <= '0;
			rem_q <= '0; dbit_q <= '0; st_out_q <= '0; slot_out_q <= '0;
		end else begin
			if (st_q == oaht_pkg::S_CLEAR) clr_q <= clr_q + 1'b1;
			if (cfg_valid && cfg_ready) mode_q <= cfg_data;
			if (m_tvalid && m_tready) m_tvalid <= 1'b0;
			unique case (st_q)
				oaht_pkg::S_IDLE: if (s_tvalid && s_tready) begin
					req_q <= s_tuser;
					key_q <= s_tdata[30:0];
					addr_q <= s_tdata[AddrW-1:0];
					n_q <= '0;
					st_out_q <= oaht_pkg::ST_NOT_FOUND;
					slot_out_q <= '0;
				end
				oaht_pkg::S_HOME: begin
					rem_q <= '0; dbit_q <= 5'd30;
					if (rd_empty) begin
						occ_q <= occ_q + 1'b1;
						st_out_q <= oaht_pkg::ST_OK; slot_out_q <= addr_q;
					end else begin
						st_out_q <= oaht_pkg::ST_FULL;
					end
				end
				oaht_pkg::S_DIV: begin
					rem_q <= rnext;
					if (dbit_q != 5'd0) dbit_q <= dbit_q - 1'b1;
				end
				oaht_pkg::S_PROBE_ADDR: begin
					rem_q <= rnext; addr_q <= paddr;
					if (mode_q == oaht_pkg::MODE_DOUBLE) coll_q <= coll_q + 1'b1;
				end
				oaht_pkg::S_PROBE_CHK: begin
					rem_q <= '0; dbit_q <= 5'd30;
					if (rd_empty) begin
						occ_q <= occ_q + 1'b1;
						st_out_q <= oaht_pkg::ST_OK; slot_out_q <= addr_q;
					end else begin
						if (mode_q != oaht_pkg::MODE_DOUBLE) coll_q <= coll_q + 1'b1;
						n_q <= n_q + 1'b1;
					end
				end
				oaht_pkg::S_SCAN_CHK: begin
					if (!rd_empty && rd_key == key_q) begin
						st_out_q <= oaht_pkg::ST_OK; slot_out_q <= addr_q;
						if (req_q == oaht_pkg::REQ_REMOVE && occ_q != '0) occ_q <= occ_q - 1'b1;
					end else begin
						n_q <= n_q + 1'b1;
						addr_q <= addr_q + 1'b1;
					end
				end
				oaht_pkg::S_DONE: m_tvalid <= 1'b1;
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

@@ tb/testbench.sv @@
`default_nettype none
module testbench;

	localparam int Slots = 1024;
	localparam int WatchLimit = 200000;
	localparam logic [31:0] EmptyKey = 32'hFFFF_FFFF;
	// Spare codes that the block must treat as search and as linear probing.
	localparam logic [1:0] ReqSpare = 2'd3;
	localparam logic [1:0] ModeSpare = 2'd3;

	typedef struct packed {
		logic [1:0]  req;
		logic [30:0] key;
	} request_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [9:0]  slot;
		logic [10:0] occ;
		logic [31:0] coll;
	} answer_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_data = 2'd0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;
	logic [1:0]  m_tuser;

	// Shadow copy of the table contents and counters.
	logic [31:0] shadow_keys [Slots];
	logic [10:0] shadow_occ;
	logic [31:0] shadow_coll;
	logic [1:0]  shadow_mode;

	request_t pending_reqs[$];
	answer_t  awaited[$];
	int       errors = 0;
	logic     hold_req = 1'b0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	open_addressing_hash_table u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	// Computes the answer of the table to one request and updates the shadow state.
	function automatic answer_t hash_table_answer(request_t r);
		answer_t a;
		logic [31:0] k;
		int home, idx;
		longint unsigned i;
		logic hit;
		k = {1'b0, r.key};
		home = int'(k % Slots);
		a.status = oaht_pkg::ST_NOT_FOUND;
		a.slot = '0;
		if (r.req == oaht_pkg::REQ_INSERT) begin
			if (shadow_keys[home] == EmptyKey) begin
				shadow_keys[home] = k;
				shadow_occ++;
				a.status = oaht_pkg::ST_OK;
				a.slot = home[9:0];
			end else if (shadow_occ >= Slots) begin
				a.status = oaht_pkg::ST_FULL;
			end else begin
				a.status = oaht_pkg::ST_FULL;
				for (int n = 0; n < Slots; n++) begin
					if (shadow_mode == oaht_pkg::MODE_QUAD) begin
						i = n;
						idx = int'((longint'(k) + i * i) % Slots);
					end else if (shadow_mode == oaht_pkg::MODE_DOUBLE) begin
						i = n + 1;
						idx = int'((longint'(home) + i - (longint'(k) % i)) % Slots);
						shadow_coll++;
					end else begin
						idx = (home + n) % Slots;
					end
					if (shadow_keys[idx] == EmptyKey) begin
						shadow_keys[idx] = k;
						shadow_occ++;
						a.status = oaht_pkg::ST_OK;
						a.slot = idx[9:0];
						break;
					end
					if (shadow_mode != oaht_pkg::MODE_DOUBLE)
						shadow_coll++;
				end
			end
		end else begin
			hit = 1'b0;
			for (int n = 0; n < Slots && !hit; n++) begin
				idx = (home + n) % Slots;
				if (shadow_keys[idx] == k) begin
					hit = 1'b1;
					a.status = oaht_pkg::ST_OK;
					a.slot = idx[9:0];
					if (r.req == oaht_pkg::REQ_REMOVE) begin
						shadow_keys[idx] = EmptyKey;
						if (shadow_occ > 0)
							shadow_occ--;
					end
				end
			end
		end
		a.occ = shadow_occ;
		a.coll = shadow_coll;
		return a;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch in %s: got %0d, expected %0d at %0t", what, got, want, $time);
		errors++;
	endtask

	// Driver: offers queued requests in bursts separated by random gaps.
	int burst_left = 0;
	int gap_left = 0;
	always @(posedge clk) begin
		request_t r;
		logic next_valid;
		logic taken;
		taken = s_tvalid && s_tready;
		if (taken)
			awaited.push_back(hash_table_answer({s_tuser, s_tdata[30:0]}));
		next_valid = s_tvalid && !taken;
		if (!next_valid && arst_n) begin
			if (burst_left == 0 && gap_left == 0) begin
				burst_left = $urandom_range(1, 20);
				gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			end
			if (gap_left > 0) begin
				gap_left--;
			end else if (pending_reqs.size() > 0) begin
				r = pending_reqs.pop_front();
				burst_left--;
				s_tdata <= {1'b0, r.key};
				s_tuser <= r.req;
				next_valid = 1'b1;
			end
		end
		s_tvalid <= next_valid;
	end

	// Receiver: its own stall pattern, plus a long hold-off when requested.
	logic hold_seen = 1'b0;
	int   hold_left = 0;
	int   stall_phase = 0;
	always @(posedge clk) begin
		stall_phase = (stall_phase + 1) % 64;
		if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left = 400;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (stall_phase < 24) begin
			m_tready <= 1'b1;
		end else begin
			m_tready <= ($urandom_range(0, 2) != 0);
		end
	end

	// Monitor: compares each result beat with the oldest expectation.
	always @(posedge clk) begin
		answer_t a;
		if (m_tvalid && m_tready) begin
			if (awaited.size() == 0) begin
				$display("unexpected result beat at %0t", $time);
				errors++;
			end else begin
				a = awaited.pop_front();
				if (m_tuser != a.status)
					report_mismatch("status", m_tuser, a.status);
				if (m_tdata[9:0] != a.slot)
					report_mismatch("slot_index", m_tdata[9:0], a.slot);
				if (m_tdata[20:10] != a.occ)
					report_mismatch("occupancy", m_tdata[20:10], a.occ);
				if (m_tdata[52:21] != a.coll)
					report_mismatch("collision_total", m_tdata[52:21], a.coll);
			end
		end
	end

	// Watchdog: ends the run when nothing moves for too long.
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WatchLimit) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic wait_drained();
		while (pending_reqs.size() > 0 || awaited.size() > 0 || s_tvalid)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_mode(logic [1:0] mode);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data <= mode;
		@(posedge clk);
		while (!(cfg_valid && cfg_ready))
			@(posedge clk);
		shadow_mode = mode;
		cfg_valid <= 1'b0;
	endtask

	task automatic add_req(logic [1:0] req, logic [30:0] key);
		pending_reqs.push_back({req, key});
	endtask

	// Random keys lean toward a few home slots so that probing gets exercised.
	task automatic add_random(int count);
		logic [30:0] k;
		int pick;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 9);
			if (pick < 6)
				k = 31'(($urandom_range(0, 15) << 10) | $urandom_range(0, 47));
			else if (pick < 8)
				k = 31'($urandom_range(0, 127));
			else
				k = 31'($urandom);
			pick = $urandom_range(0, 19);
			if (pick < 10)
				add_req(oaht_pkg::REQ_INSERT, k);
			else if (pick < 14)
				add_req(oaht_pkg::REQ_REMOVE, k);
			else if (pick < 19)
				add_req(oaht_pkg::REQ_SEARCH, k);
			else
				add_req(ReqSpare, k);
		end
	endtask

	initial begin
		for (int n = 0; n < Slots; n++)
			shadow_keys[n] = EmptyKey;
		shadow_occ = '0;
		shadow_coll = '0;
		shadow_mode = oaht_pkg::MODE_LINEAR;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: extreme keys, duplicates, collisions, misses and the spare type.
		write_mode(oaht_pkg::MODE_LINEAR);
		add_req(oaht_pkg::REQ_INSERT, 31'd0);
		add_req(oaht_pkg::REQ_INSERT, 31'h7FFF_FFFF);
		add_req(oaht_pkg::REQ_INSERT, 31'd0);
		add_req(oaht_pkg::REQ_INSERT, 31'd1024);
		add_req(oaht_pkg::REQ_INSERT, 31'd2047);
		add_req(oaht_pkg::REQ_SEARCH, 31'd1024);
		add_req(oaht_pkg::REQ_SEARCH, 31'h7FFF_FFFF);
		add_req(oaht_pkg::REQ_SEARCH, 31'd5);
		add_req(oaht_pkg::REQ_REMOVE, 31'd0);
		add_req(oaht_pkg::REQ_REMOVE, 31'd0);
		add_req(oaht_pkg::REQ_REMOVE, 31'd0);
		add_req(oaht_pkg::REQ_REMOVE, 31'd12345);
		add_req(ReqSpare, 31'd1024);
		add_req(oaht_pkg::REQ_INSERT, 31'h5555_5555);
		add_req(oaht_pkg::REQ_INSERT, 31'h2AAA_AAAA);
		add_req(oaht_pkg::REQ_SEARCH, 31'h2AAA_AAAA);
		add_random(160);

		write_mode(oaht_pkg::MODE_QUAD);
		add_random(130);
		write_mode(oaht_pkg::MODE_DOUBLE);
		add_random(130);
		write_mode(ModeSpare);
		add_random(60);

		// Long receiver hold-off while requests keep coming.
		write_mode(oaht_pkg::MODE_LINEAR);
		hold_req <= ~hold_req;
		add_random(150);

		// A few last requests across a mode change.
		write_mode(oaht_pkg::MODE_LINEAR);
		add_req(oaht_pkg::REQ_INSERT, 31'd4096);
		add_req(oaht_pkg::REQ_SEARCH, 31'd1023);
		write_mode(oaht_pkg::MODE_QUAD);
		add_req(oaht_pkg::REQ_INSERT, 31'd77);
		wait_drained();
		repeat (100) @(posedge clk);

		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
`default_nettype wire
